// ===== design/bitc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitc_pkg
// Shared types, codes and constants of the backlight idle timeout controller.
// ---------------------------------------------------------------------------
package bitc_pkg;

  localparam int ELAPSED_SHIFT   = 14;
  localparam int SLEEP_EXTRA     = 10;
  localparam int NORMAL_DIM_HOLD = 5;

  localparam int DELAY_W    = 10;
  localparam int HOLD_W     = 8;
  localparam int COUNT_W    = 11;
  localparam int TICK_W     = 32;
  localparam int ELAPSED_W  = TICK_W - ELAPSED_SHIFT;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int IN_FIELD_W  = TICK_W + 5;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 6;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [DELAY_W-1:0] SLEEP_DELAY_RESET = DELAY_W'(200);
  localparam logic [HOLD_W-1:0]  DIM_HOLD_DEFAULT  = HOLD_W'(10);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_HOLD_PS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_SAVING = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_ON    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DIM     = CFG_IDX_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_ACTIVITY  = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_LOW_POWER = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TURN_ON  = 3'd1,
    CMD_WAKE     = 3'd2,
    CMD_HALF     = 3'd3,
    CMD_SLEEP    = 3'd4,
    CMD_ACT_HALF = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_AWAKE  = 2'd0,
    MODE_DIMMED = 2'd1,
    MODE_ASLEEP = 2'd2
  } mode_t;

  typedef struct packed {
    logic [DELAY_W-1:0] sleep_delay;
    logic [HOLD_W-1:0]  dim_hold_power_saving;
    logic               power_saving;
    logic               always_on;
    logic               hold_dim;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TICK_W-1:0] now_ticks;
    logic              charger_connected;
    logic              battery_low;
    logic              open_display;
    logic              low_power_request;
    logic              display_needed;
  } item_t;

  typedef struct packed {
    cmd_t  display_command;
    mode_t display_state;
    logic  running;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bitc_cfg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitc_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module bitc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bitc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bitc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bitc_pkg::cfg_t                       cfg
);
  import bitc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic [HOLD_W-1:0] hold_wr;

  assign hold_wr = cfg_wdata[HOLD_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLEEP_DELAY:  cfg_nxt.sleep_delay = cfg_wdata[DELAY_W-1:0];
        // zero is not a valid hold, it falls back to the default
        CFG_DIM_HOLD_PS:  cfg_nxt.dim_hold_power_saving =
                            (hold_wr == '0) ? DIM_HOLD_DEFAULT : hold_wr;
        CFG_POWER_SAVING: cfg_nxt.power_saving = cfg_wdata[0];
        CFG_ALWAYS_ON:    cfg_nxt.always_on    = cfg_wdata[0];
        CFG_HOLD_DIM:     cfg_nxt.hold_dim     = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_delay           <= SLEEP_DELAY_RESET;
      cfg_r.dim_hold_power_saving <= DIM_HOLD_DEFAULT;
      cfg_r.power_saving          <= 1'b0;
      cfg_r.always_on             <= 1'b0;
      cfg_r.hold_dim              <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== design/bitc_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bitc_core
// Display mode state and the per-event update logic; one event per cycle while fire is high.
// ---------------------------------------------------------------------------
module bitc_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  bitc_pkg::item_t  item,
  input  bitc_pkg::cfg_t   cfg,
  output bitc_pkg::result_t res
);
  import bitc_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic               svc_r, svc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0]  mark_r, mark_nxt;
  logic               lpf_r, lpf_nxt;

  logic                 lp;
  logic [TICK_W-1:0]    diff;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_late;
  logic [COUNT_W-1:0]   delay_ext;
  logic [COUNT_W-1:0]   sleep_at;
  logic [HOLD_W-1:0]    hold;
  logic                 dimmed_now;
  logic                 ps_dim;
  logic                 act_open;
  cmd_t                 act_plain;
  cmd_t                 cmd_v;

  assign lp        = !item.charger_connected && (item.battery_low || lpf_r);
  assign diff      = item.now_ticks - mark_r;
  assign elapsed   = diff[TICK_W-1:ELAPSED_SHIFT];
  assign delay_ext = {1'b0, cfg.sleep_delay};
  assign sleep_at  = delay_ext + COUNT_W'(SLEEP_EXTRA);

  always_comb begin
    mode_nxt     = mode_r;
    svc_nxt      = svc_r;
    cnt_nxt      = cnt_r;
    mark_nxt     = mark_r;
    lpf_nxt      = lpf_r;
    cmd_v        = CMD_NONE;
    dimmed_now   = 1'b0;
    ps_dim       = 1'b0;
    hold         = HOLD_W'(NORMAL_DIM_HOLD);
    elapsed_late = elapsed;
    act_open     = 1'b0;
    act_plain    = CMD_NONE;

    case (op_t'(item.op))
      OP_TICK: begin
        if (svc_r) begin
          if (cnt_nxt != COUNT_MAX) cnt_nxt = cnt_nxt + 1'b1;
          if (cfg.always_on) begin
            cnt_nxt = '0;
          end else if (cnt_nxt == delay_ext && mode_r != MODE_DIMMED) begin
            if (elapsed < ELAPSED_W'(cfg.sleep_delay >> 1)) begin
              if (cnt_nxt != '0) cnt_nxt = cnt_nxt - 1'b1;
            end else begin
              mark_nxt   = item.now_ticks;
              mode_nxt   = MODE_DIMMED;
              cmd_v      = CMD_HALF;
              dimmed_now = 1'b1;
            end
          end
          // a dim in this same tick restarts the elapsed time at zero
          if (dimmed_now) elapsed_late = '0;
          ps_dim = (mode_nxt == MODE_DIMMED) && cfg.power_saving && !lp;
          if (ps_dim) hold = cfg.dim_hold_power_saving;
          if (cnt_nxt == sleep_at || ps_dim) begin
            if (cfg.hold_dim) begin
              cnt_nxt = delay_ext;
            end else if (elapsed_late < ELAPSED_W'(hold)) begin
              if (cnt_nxt != '0) cnt_nxt = cnt_nxt - 1'b1;
            end else begin
              svc_nxt  = 1'b0;
              mode_nxt = MODE_ASLEEP;
              cmd_v    = CMD_SLEEP;
            end
          end
        end
      end
      OP_ACTIVITY: begin
        cnt_nxt  = lp ? delay_ext : '0;
        mark_nxt = item.now_ticks;
        if (mode_r == MODE_ASLEEP) begin
          if (!svc_r) begin
            act_open  = 1'b1;
            act_plain = CMD_TURN_ON;
            svc_nxt   = 1'b1;
          end
        end else if (mode_r == MODE_DIMMED && !cfg.power_saving && !lp) begin
          mode_nxt = MODE_AWAKE;
          cmd_v    = CMD_WAKE;
        end
      end
      OP_START: begin
        if (!svc_r) begin
          mark_nxt  = item.now_ticks;
          act_open  = item.open_display;
          act_plain = CMD_TURN_ON;
          svc_nxt   = 1'b1;
        end
      end
      OP_STOP: begin
        if (svc_r) begin
          act_open  = item.open_display;
          act_plain = CMD_WAKE;
          svc_nxt   = 1'b0;
        end
      end
      OP_LOW_POWER: begin
        lpf_nxt = item.low_power_request;
        if (item.low_power_request && item.display_needed) begin
          mark_nxt = item.now_ticks;
          cnt_nxt  = delay_ext;
          mode_nxt = MODE_DIMMED;
          cmd_v    = CMD_ACT_HALF;
        end
      end
      default: cmd_v = CMD_NONE;
    endcase

    // start, stop or wake-up activity that also drives the display
    if (act_open) begin
      if (cfg.power_saving || lp) begin
        if (lp) cnt_nxt = delay_ext;
        mode_nxt = MODE_DIMMED;
        cmd_v    = CMD_ACT_HALF;
      end else begin
        mode_nxt = MODE_AWAKE;
        cmd_v    = act_plain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AWAKE;
      svc_r  <= 1'b0;
      cnt_r  <= '0;
      mark_r <= '0;
      lpf_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      svc_r  <= svc_nxt;
      cnt_r  <= cnt_nxt;
      mark_r <= mark_nxt;
      lpf_r  <= lpf_nxt;
    end
  end

  assign res.display_command = cmd_v;
  assign res.display_state   = mode_nxt;
  assign res.running         = svc_nxt;

endmodule

`default_nettype wire

// ===== design/backlight_idle_timeout_controller.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// backlight_idle_timeout_controller
// Display inactivity controller: awake, dimmed and asleep driven by events.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : event beats; in_tuser carries the op code, in_tdata the tick value
//           and the charger, battery, low power and display flags.
//   out_* : one result beat per event: display command, display state after
//           the event and the running flag.
//   cfg_* : register writes, taken at any edge with cfg_we high; only write
//           while no event is in flight.
// An accepted event beat passes the input register, then the update logic and
// the result register behind it.
// Throughput: one event per cycle while the result side is free; the state update is a single pass of
// compare and subtract logic between the input and result registers.
// Reset (rst_n low, synchronous) clears both register stages, returns the
// display to awake with the service stopped and loads the register defaults.
// When out_tready is low with a result waiting, the result register holds; an
// empty input register still takes one more beat before in_tready drops.
// ---------------------------------------------------------------------------
module backlight_idle_timeout_controller (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: now_ticks, charger_connected, battery_low, open_display,
  //           low_power_request, display_needed, zero fill
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [bitc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op
  input  wire logic [bitc_pkg::OP_W-1:0]        in_tuser,
  // out_tdata: display_command, display_state, running, zero fill
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [bitc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [bitc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bitc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bitc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  result_t res;
  result_t out_res_r;
  logic    out_free;
  logic    s1_fire;
  logic    in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  bitc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bitc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free)  out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op                <= in_tuser;
      item_r.now_ticks         <= in_tdata[TICK_W-1:0];
      item_r.charger_connected <= in_tdata[TICK_W];
      item_r.battery_low       <= in_tdata[TICK_W+1];
      item_r.open_display      <= in_tdata[TICK_W+2];
      item_r.low_power_request <= in_tdata[TICK_W+3];
      item_r.display_needed    <= in_tdata[TICK_W+4];
    end
    if (s1_fire) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-OUT_FIELD_W)'(0), out_res_r.running,
                       out_res_r.display_state, out_res_r.display_command};

`ifndef ASSERT_OFF
  a_sleep_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.display_command == CMD_SLEEP
      |-> !out_res_r.running && out_res_r.display_state == MODE_ASLEEP)
    else $error("sleep command with service running or display not asleep");

  a_half_dimmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.display_command == CMD_HALF ||
                    out_res_r.display_command == CMD_ACT_HALF)
      |-> out_res_r.display_state == MODE_DIMMED)
    else $error("half light command without dimmed state");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed event produced no result beat");
`endif

endmodule

`default_nettype wire

// ===== dv/backlight_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// backlight_checker
// Watches the event, result and register ports of the backlight idle timeout
// controller, keeps its own copy of the display state and registers, works
// out the result of every accepted event and compares each result beat with
// the oldest one still due.
// ---------------------------------------------------------------------------
module backlight_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [bitc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [bitc_pkg::OP_W-1:0]        in_tuser,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [bitc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [bitc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bitc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned                           fail_count,
  output int unsigned                           pending
);
  import bitc_pkg::*;

  cfg_t               regs;
  mode_t              mode;
  logic               svc_on;
  logic [COUNT_W-1:0] idle_cnt;
  logic [TICK_W-1:0]  mark;
  logic               lp_flag;

  result_t     due_status[$];
  result_t     want;
  item_t       taken;
  int unsigned fails = 0;

  function automatic logic [ELAPSED_W-1:0] units_since(input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] diff;
    diff = now - mark;
    return diff[TICK_W-1:ELAPSED_SHIFT];
  endfunction

  // start, stop or wake-up activity that also drives the display
  function automatic cmd_t drive_display(input logic lp, input cmd_t plain);
    if (regs.power_saving || lp) begin
      if (lp) idle_cnt = COUNT_W'(regs.sleep_delay);
      mode = MODE_DIMMED;
      return CMD_ACT_HALF;
    end
    mode = MODE_AWAKE;
    return plain;
  endfunction

  function automatic cmd_t begin_service(input logic show, input logic lp,
                                         input logic [TICK_W-1:0] now);
    cmd_t c;
    c = CMD_NONE;
    if (svc_on) return CMD_NONE;
    mark = now;
    if (show) c = drive_display(lp, CMD_TURN_ON);
    svc_on = 1'b1;
    return c;
  endfunction

  function automatic result_t next_backlight(input item_t ev);
    cmd_t        c;
    logic        lp;
    logic        ps_dim;
    int unsigned delay;
    int unsigned hold;
    result_t     r;
    c     = CMD_NONE;
    lp    = !ev.charger_connected && (ev.battery_low || lp_flag);
    delay = regs.sleep_delay;
    case (ev.op)
      OP_TICK: begin
        if (svc_on) begin
          if (idle_cnt != COUNT_MAX) idle_cnt = idle_cnt + 1'b1;
          if (regs.always_on) begin
            idle_cnt = '0;
          end else if (idle_cnt == delay && mode != MODE_DIMMED) begin
            if (units_since(ev.now_ticks) < (delay >> 1)) begin
              if (idle_cnt != 0) idle_cnt = idle_cnt - 1'b1;
            end else begin
              mark = ev.now_ticks;
              mode = MODE_DIMMED;
              c    = CMD_HALF;
            end
          end
          ps_dim = (mode == MODE_DIMMED) && regs.power_saving && !lp;
          if (idle_cnt == delay + SLEEP_EXTRA || ps_dim) begin
            if (regs.hold_dim) begin
              idle_cnt = COUNT_W'(delay);
            end else begin
              if (ps_dim) hold = regs.dim_hold_power_saving;
              else hold = NORMAL_DIM_HOLD;
              if (units_since(ev.now_ticks) < hold) begin
                if (idle_cnt != 0) idle_cnt = idle_cnt - 1'b1;
              end else begin
                svc_on = 1'b0;
                mode   = MODE_ASLEEP;
                c      = CMD_SLEEP;
              end
            end
          end
        end
      end
      OP_ACTIVITY: begin
        idle_cnt = '0;
        mark     = ev.now_ticks;
        if (lp) idle_cnt = COUNT_W'(delay);
        if (mode == MODE_ASLEEP) begin
          c = begin_service(1'b1, lp, ev.now_ticks);
        end else if (mode == MODE_DIMMED && !regs.power_saving && !lp) begin
          mode = MODE_AWAKE;
          c    = CMD_WAKE;
        end
      end
      OP_START: c = begin_service(ev.open_display, lp, ev.now_ticks);
      OP_STOP: begin
        if (svc_on) begin
          if (ev.open_display) c = drive_display(lp, CMD_WAKE);
          svc_on = 1'b0;
        end
      end
      OP_LOW_POWER: begin
        lp_flag = ev.low_power_request;
        if (ev.low_power_request && ev.display_needed) begin
          mark     = ev.now_ticks;
          idle_cnt = COUNT_W'(delay);
          mode     = MODE_DIMMED;
          c        = CMD_ACT_HALF;
        end
      end
      default: ;
    endcase
    r.display_command = c;
    r.display_state   = mode;
    r.running         = svc_on;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.sleep_delay           = SLEEP_DELAY_RESET;
      regs.dim_hold_power_saving = DIM_HOLD_DEFAULT;
      regs.power_saving          = 1'b0;
      regs.always_on             = 1'b0;
      regs.hold_dim              = 1'b0;
      mode     = MODE_AWAKE;
      svc_on   = 1'b0;
      idle_cnt = '0;
      mark     = '0;
      lp_flag  = 1'b0;
      due_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLEEP_DELAY: regs.sleep_delay = cfg_wdata[DELAY_W-1:0];
          CFG_DIM_HOLD_PS: begin
            // a zero hold falls back to the default
            if (cfg_wdata[HOLD_W-1:0] == '0) regs.dim_hold_power_saving = DIM_HOLD_DEFAULT;
            else regs.dim_hold_power_saving = cfg_wdata[HOLD_W-1:0];
          end
          CFG_POWER_SAVING: regs.power_saving = cfg_wdata[0];
          CFG_ALWAYS_ON:    regs.always_on    = cfg_wdata[0];
          CFG_HOLD_DIM:     regs.hold_dim     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_status.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result beat with nothing due: tdata %0h", out_tdata);
        end else begin
          want = due_status.pop_front();
          if (want.display_command !== out_tdata[2:0] ||
              want.display_state !== out_tdata[4:3] ||
              want.running !== out_tdata[5]) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp cmd %0d state %0d run %0d got cmd %0d state %0d run %0d",
                       want.display_command, want.display_state, want.running,
                       out_tdata[2:0], out_tdata[4:3], out_tdata[5]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken.op                = in_tuser;
        taken.now_ticks         = in_tdata[TICK_W-1:0];
        taken.charger_connected = in_tdata[TICK_W];
        taken.battery_low       = in_tdata[TICK_W+1];
        taken.open_display      = in_tdata[TICK_W+2];
        taken.low_power_request = in_tdata[TICK_W+3];
        taken.display_needed    = in_tdata[TICK_W+4];
        due_status.push_back(next_backlight(taken));
      end
    end
    fail_count <= fails;
    pending    <= due_status.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the backlight idle timeout controller: a short directed run
// of corner events, a long tick run that drives the idle counter into
// saturation, then random event phases under several register settings, most
// with random gaps on the event side and back-pressure on the result side.
// ---------------------------------------------------------------------------
module tb_top;
  import bitc_pkg::*;

  localparam int unsigned      UNIT        = 1 << ELAPSED_SHIFT;
  localparam int unsigned      CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0]  OP_UNUSED_FIRST = OP_W'(OP_LOW_POWER + 1);

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int unsigned       tx_idle_pct = 31;
  int unsigned       rx_idle_pct = 64;
  int unsigned       cycles      = 0;
  logic [TICK_W-1:0] sys_ticks   = '0;
  int unsigned       check_fails;
  int unsigned       results_due;

  backlight_idle_timeout_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  backlight_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (check_fails),
    .pending    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    cycles     <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic item_t mk_event(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] now,
                                     input logic charger, input logic batt, input logic show,
                                     input logic req, input logic needed);
    item_t ev;
    ev.op                = op;
    ev.now_ticks         = now;
    ev.charger_connected = charger;
    ev.battery_low       = batt;
    ev.open_display      = show;
    ev.low_power_request = req;
    ev.display_needed    = needed;
    return ev;
  endfunction

  function automatic item_t random_event();
    item_t       ev;
    int unsigned pick;
    // time mostly creeps forward by up to three elapsed units, now and then jumps
    pick = $urandom_range(99);
    if (pick < 5) sys_ticks = $urandom();
    else if (pick >= 15) sys_ticks = sys_ticks + $urandom_range(3 * UNIT);
    pick = $urandom_range(99);
    if (pick < 55) ev.op = OP_TICK;
    else if (pick < 65) ev.op = OP_ACTIVITY;
    else if (pick < 75) ev.op = OP_START;
    else if (pick < 83) ev.op = OP_STOP;
    else if (pick < 95) ev.op = OP_LOW_POWER;
    else ev.op = OP_W'(OP_UNUSED_FIRST + $urandom_range(2));
    ev.now_ticks         = sys_ticks;
    ev.charger_connected = ($urandom_range(99) < 40);
    ev.battery_low       = ($urandom_range(99) < 30);
    ev.open_display      = ($urandom_range(99) < 70);
    ev.low_power_request = ($urandom_range(99) < 30);
    ev.display_needed    = $urandom_range(1);
    return ev;
  endfunction

  task automatic send_event(input item_t ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.op;
    in_tdata  <= IN_TDATA_W'({ev.display_needed, ev.low_power_request, ev.open_display,
                              ev.battery_low, ev.charger_connected, ev.now_ticks});
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off events until every result has come out
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned delay, input int unsigned hold,
                              input logic ps, input logic ao, input logic hd);
    write_reg(CFG_SLEEP_DELAY, CFG_DATA_W'(delay));
    write_reg(CFG_DIM_HOLD_PS, CFG_DATA_W'(hold));
    write_reg(CFG_POWER_SAVING, CFG_DATA_W'(ps));
    write_reg(CFG_ALWAYS_ON, CFG_DATA_W'(ao));
    write_reg(CFG_HOLD_DIM, CFG_DATA_W'(hd));
    // an index past the last register must be dropped
    write_reg(CFG_IDX_W'(CFG_HOLD_DIM + 1 + $urandom_range(2)), CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned delay, input int unsigned hold,
                           input logic ps, input logic ao, input logic hd,
                           input int unsigned beats);
    wait_quiet();
    program_regs(delay, hold, ps, ao, hd);
    repeat (beats) begin
      if ($urandom_range(99) == 0) wait_quiet();
      send_event(random_event());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with a short delay of two ticks
    program_regs(2, 1, 1'b0, 1'b0, 1'b0);
    send_event(mk_event(OP_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_UNUSED_FIRST, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(OP_W'(OP_UNUSED_FIRST + 1), '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(OP_W'(OP_UNUSED_FIRST + 2), '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(OP_STOP, '0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_START, '0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_START, '0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    // delay reached too early: counter steps back
    send_event(mk_event(OP_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_TICK, TICK_W'(2 * UNIT), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_TICK, TICK_W'(2 * UNIT), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_ACTIVITY, TICK_W'(3 * UNIT), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_LOW_POWER, TICK_W'(4 * UNIT), 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(OP_ACTIVITY, TICK_W'(5 * UNIT), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_TICK, TICK_W'(9 * UNIT), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_STOP, TICK_W'(9 * UNIT), 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_LOW_POWER, TICK_W'(9 * UNIT), 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_event(mk_event(OP_START, TICK_W'(9 * UNIT), 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_STOP, TICK_W'(9 * UNIT), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(OP_ACTIVITY, TICK_W'(9 * UNIT), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_START, '1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    // tick value wraps past zero
    send_event(mk_event(OP_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_STOP, '0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

    // park the counter at 1023, then drop the delay so ticks climb to saturation
    wait_quiet();
    program_regs(1023, 10, 1'b0, 1'b0, 1'b0);
    send_event(mk_event(OP_START, $urandom(), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_LOW_POWER, $urandom(), 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(OP_ACTIVITY, $urandom(), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_LOW_POWER, $urandom(), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    wait_quiet();
    program_regs(0, 10, 1'b0, 1'b0, 1'b0);
    repeat (1100) send_event(mk_event(OP_TICK, $urandom(), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_event(mk_event(OP_STOP, $urandom(), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));

    run_phase(0, 1, 1'b0, 1'b0, 1'b0, 150);
    run_phase(1023, 255, 1'b1, 1'b0, 1'b0, 150);
    tx_idle_pct = 64;
    rx_idle_pct = 31;
    run_phase($urandom_range(2, 24), 0, 1'b0, 1'b0, 1'b1, 150);
    run_phase($urandom_range(2, 24), $urandom_range(1, 8), 1'b1, 1'b0, 1'b0, 150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase($urandom_range(2, 24), $urandom_range(1, 255), 1'b0, 1'b1, 1'b0, 150);
    run_phase($urandom_range(2, 24), 3, 1'b0, 1'b0, 1'b0, 150);

    wait_quiet();
    if (check_fails == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/bitc_pkg.sv
design/bitc_cfg.sv
design/bitc_core.sv
design/backlight_idle_timeout_controller.sv
dv/backlight_checker.sv
dv/tb_top.sv
